/* rtl/core/vertex_normal_accumulator_top_defines.svh */
// Assertion macros used by the port-level checker of the vertex normal accumulator.
`ifndef VERTEX_NORMAL_ACCUMULATOR_TOP_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VNACC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define VNACC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/vnacc_pkg.sv */
// Package with constants, types and helper functions of the vertex normal accumulator.
`timescale 1ns / 1ps
package vnacc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int COORD_BITS   = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int POS_W        = 16;
  localparam int ACC_W        = 48;
  localparam int EDGE_W       = POS_W + 1;
  localparam int PROD_W       = 2 * EDGE_W;
  localparam int CROSS_W      = PROD_W + 1;
  localparam int NRM_W        = 16;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_TRI  = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_EDGE,
    S_CROSS,
    S_ACC_RD,
    S_ACC_WR,
    S_READ,
    S_NORM,
    S_WAIT
  } top_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SCALE,
    N_SQUARE,
    N_ROOT,
    N_DIVI,
    N_DIV,
    N_DONE
  } norm_state_t;

  typedef struct packed {
    logic start;
    logic invalid;
  } norm_req_t;

  typedef struct packed {
    logic done;
    logic degenerate;
  } norm_rsp_t;

  function automatic logic signed [POS_W-1:0] coord_in(input logic signed [POS_W-1:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic signed [31:0] w;
    hi = (32'sd1 <<< (COORD_BITS - 1)) - 32'sd1;
    lo = -hi - 32'sd1;
    w  = 32'(v);
    if (w > hi) w = hi;
    if (w < lo) w = lo;
    return w[POS_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [CROSS_W-1:0] d);
    logic signed [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + (ACC_W+1)'(d);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

/* rtl/core/vnacc_norm.sv */
// Iterative normalizer that scales an accumulated normal to unit length in Q1.14.
`timescale 1ns / 1ps
module vnacc_norm
  import vnacc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  norm_req_t               req,
  input  logic signed [ACC_W-1:0] sum_x,
  input  logic signed [ACC_W-1:0] sum_y,
  input  logic signed [ACC_W-1:0] sum_z,
  output norm_rsp_t               rsp,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z
);

  norm_state_t state, state_next;

  logic [ACC_W-1:0] mag [3];
  logic [2:0]       neg;
  logic [ACC_W-1:0] m;
  logic [59:0]      sq;
  logic [63:0]      len2;
  logic [63:0]      x;
  logic [63:0]      res;
  logic [63:0]      bitv;
  logic [31:0]      r;
  logic [30:0]      rem;
  logic [14:0]      nlow;
  logic [14:0]      q;
  logic [4:0]       cnt;
  logic [1:0]       comp;
  logic             deg;
  logic signed [NRM_W-1:0] nrm [3];

  logic [63:0] root_t;
  logic        root_ge;
  logic [44:0] div_n;
  logic [31:0] div_sh;
  logic        div_ge;
  logic [14:0] q_nx;
  logic        zero_in;

  assign zero_in = (sum_x == '0) && (sum_y == '0) && (sum_z == '0);

  always_comb begin
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
  end

  assign root_t  = res + bitv;
  assign root_ge = x >= root_t;
  assign div_n   = {mag[comp][29:0], 14'd0} + 45'(r >> 1);
  assign div_sh  = {rem, nlow[14]};
  assign div_ge  = div_sh >= r;
  assign q_nx    = {q[13:0], div_ge};

  always_comb begin
    state_next = state;
    unique case (state)
      N_IDLE:   if (req.start) state_next = (req.invalid || zero_in) ? N_DONE : N_SCALE;
      N_SCALE:  if (m < (48'd1 << 30) && m >= (48'd1 << 29)) state_next = N_SQUARE;
      N_SQUARE: if (cnt == 5'd3) state_next = N_ROOT;
      N_ROOT:   if (cnt == 5'd31) state_next = N_DIVI;
      N_DIVI:   state_next = N_DIV;
      N_DIV:    if (cnt == 5'd14) state_next = (comp == 2'd2) ? N_DONE : N_DIVI;
      N_DONE:   state_next = N_IDLE;
      default:  state_next = N_IDLE;
    endcase
  end

  always_comb begin
    rsp.done       = state == N_DONE;
    rsp.degenerate = deg;
    normal_x       = nrm[0];
    normal_y       = nrm[1];
    normal_z       = nrm[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        neg    <= {sum_z[ACC_W-1], sum_y[ACC_W-1], sum_x[ACC_W-1]};
        mag[0] <= sum_x[ACC_W-1] ? ACC_W'(-sum_x) : ACC_W'(sum_x);
        mag[1] <= sum_y[ACC_W-1] ? ACC_W'(-sum_y) : ACC_W'(sum_y);
        mag[2] <= sum_z[ACC_W-1] ? ACC_W'(-sum_z) : ACC_W'(sum_z);
        deg    <= req.invalid || zero_in;
        cnt    <= '0;
        len2   <= '0;
        for (int i = 0; i < 3; i++) nrm[i] <= '0;
      end
      N_SCALE: begin
        if (m >= (48'd1 << 30)) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (m < (48'd1 << 29)) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      N_SQUARE: begin
        if (cnt != 5'd3) sq <= mag[cnt[1:0]][29:0] * mag[cnt[1:0]][29:0];
        if (cnt != 5'd0) len2 <= len2 + 64'(sq);
        if (cnt == 5'd3) begin
          cnt  <= '0;
          x    <= len2 + 64'(sq);
          res  <= '0;
          bitv <= 64'd1 << 62;
        end else begin
          cnt <= cnt + 5'd1;
        end
      end
      N_ROOT: begin
        if (root_ge) begin
          x   <= x - root_t;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          r    <= 32'(root_ge ? ((res >> 1) + bitv) : (res >> 1));
          comp <= '0;
        end
      end
      N_DIVI: begin
        rem  <= 31'(div_n[44:15]);
        nlow <= div_n[14:0];
        q    <= '0;
        cnt  <= '0;
      end
      N_DIV: begin
        rem  <= div_ge ? 31'(div_sh - r) : div_sh[30:0];
        nlow <= nlow << 1;
        q    <= q_nx;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd14) begin
          nrm[comp] <= neg[comp] ? -NRM_W'(q_nx) : NRM_W'(q_nx);
          comp      <= comp + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/vertex_normal_accumulator_top.sv */
// Top level of the vertex normal accumulator: request decode, memories and triangle datapath.
`timescale 1ns / 1ps
// Each request is taken when start is high and busy is low. A load completes in the cycle
// it is taken and leaves busy low, so loads can follow each other every cycle. A triangle
// runs through three position memory reads, the edge products on the shared multiplier,
// and a read and a write of the accumulator memory for each corner. A read of a nonzero
// normal holds busy through the one-bit-a-cycle scaling shift (up to 29 steps), the 32-step
// square root and three 15-step divisions of the normalizer; a read of a zero-length normal
// skips them. The result is on the normal ports for the one cycle in which done is high,
// the last busy cycle, and it must be taken then, since the block cannot be stalled.
module vertex_normal_accumulator_top
  import vnacc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              mode,
  input  logic [9:0]              vertex_index,
  input  logic signed [15:0]      pos_x,
  input  logic signed [15:0]      pos_y,
  input  logic signed [15:0]      pos_z,
  input  logic [9:0]              corner_a,
  input  logic [9:0]              corner_b,
  input  logic [9:0]              corner_c,
  output logic                    done,
  output logic signed [15:0]      normal_x,
  output logic signed [15:0]      normal_y,
  output logic signed [15:0]      normal_z,
  output logic                    degenerate
);

  top_state_t state, state_next;

  logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
  logic [3*ACC_W-1:0] acc_mem [MAX_VERTICES];
  logic [3*POS_W-1:0] pos_q;
  logic [3*ACC_W-1:0] acc_q;

  logic [VIDX_W-1:0] pos_addr;
  logic [VIDX_W-1:0] acc_addr;
  logic [VIDX_W-1:0] corner [3];
  logic [VIDX_W-1:0] idx;
  logic              idx_bad;
  logic [2:0]        cnt;
  logic [1:0]        k;

  logic signed [POS_W-1:0]   pa [3];
  logic signed [EDGE_W-1:0]  e1 [3];
  logic signed [EDGE_W-1:0]  e2 [3];
  logic signed [EDGE_W-1:0]  ma;
  logic signed [EDGE_W-1:0]  mb;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  hold;
  logic signed [CROSS_W-1:0] n [3];
  logic signed [POS_W-1:0]   pq [3];
  logic signed [ACC_W-1:0]   aq [3];

  logic         accept;
  mode_t        mode_in;
  logic         tri_ok;
  logic         load_we;
  logic         acc_we;
  logic [2:0]   j;
  norm_req_t    nreq;
  norm_rsp_t    nrsp;

  assign accept  = start && !busy;
  assign mode_in = mode_t'(mode);
  assign tri_ok  = 32'(corner_a) < MAX_VERTICES && 32'(corner_b) < MAX_VERTICES &&
                   32'(corner_c) < MAX_VERTICES;
  assign load_we = accept && mode_in == MODE_LOAD && 32'(vertex_index) < MAX_VERTICES;
  assign j       = cnt - 3'd1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pq[i] = pos_q[i*POS_W +: POS_W];
      aq[i] = acc_q[i*ACC_W +: ACC_W];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_in)
            MODE_TRI:  if (tri_ok) state_next = S_POS;
            MODE_READ: state_next = S_READ;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_POS:    if (cnt == 3'd2) state_next = S_EDGE;
      S_EDGE:   state_next = S_CROSS;
      S_CROSS:  if (cnt == 3'd6) state_next = S_ACC_RD;
      S_ACC_RD: state_next = S_ACC_WR;
      S_ACC_WR: state_next = (k == 2'd2) ? S_IDLE : S_ACC_RD;
      S_READ:   state_next = S_NORM;
      S_NORM:   state_next = S_WAIT;
      S_WAIT:   if (nrsp.done) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy         = state != S_IDLE;
    acc_we       = state == S_ACC_WR;
    nreq.start   = state == S_NORM;
    nreq.invalid = idx_bad;
    pos_addr     = corner[2];
    if (cnt == 3'd0) pos_addr = corner[0];
    else if (cnt == 3'd1) pos_addr = corner[1];
    acc_addr     = (state == S_ACC_RD || state == S_ACC_WR) ? corner[k] : idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      pos_mem[vertex_index[VIDX_W-1:0]] <= {coord_in(pos_z), coord_in(pos_y), coord_in(pos_x)};
    end
    pos_q <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      acc_mem[vertex_index[VIDX_W-1:0]] <= '0;
    end else if (acc_we) begin
      acc_mem[acc_addr] <= {sat_add(aq[2], n[2]), sat_add(aq[1], n[1]), sat_add(aq[0], n[0])};
    end
    acc_q <= acc_mem[acc_addr];
  end

  always_comb begin
    case (cnt)
      3'd0:    begin ma = e1[1]; mb = e2[2]; end
      3'd1:    begin ma = e1[2]; mb = e2[1]; end
      3'd2:    begin ma = e1[2]; mb = e2[0]; end
      3'd3:    begin ma = e1[0]; mb = e2[2]; end
      3'd4:    begin ma = e1[0]; mb = e2[1]; end
      3'd5:    begin ma = e1[1]; mb = e2[0]; end
      default: begin ma = '0;    mb = '0;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      corner[0] <= corner_a[VIDX_W-1:0];
      corner[1] <= corner_b[VIDX_W-1:0];
      corner[2] <= corner_c[VIDX_W-1:0];
      idx       <= vertex_index[VIDX_W-1:0];
      idx_bad   <= !(32'(vertex_index) < MAX_VERTICES);
      cnt       <= '0;
      k         <= '0;
    end else begin
      case (state)
        S_POS: begin
          if (cnt == 3'd1) begin
            for (int i = 0; i < 3; i++) pa[i] <= pq[i];
          end
          if (cnt == 3'd2) begin
            for (int i = 0; i < 3; i++) e1[i] <= EDGE_W'(pq[i]) - EDGE_W'(pa[i]);
            cnt <= '0;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_EDGE: begin
          for (int i = 0; i < 3; i++) e2[i] <= EDGE_W'(pq[i]) - EDGE_W'(pa[i]);
        end
        S_CROSS: begin
          prod <= ma * mb;
          if (cnt != 3'd0) begin
            if (!j[0]) hold <= prod;
            else n[j[2:1]] <= CROSS_W'(hold) - CROSS_W'(prod);
          end
          cnt <= cnt + 3'd1;
        end
        S_ACC_WR: k <= k + 2'd1;
        default: begin
        end
      endcase
    end
  end

  vnacc_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .req      (nreq),
    .sum_x    (aq[0]),
    .sum_y    (aq[1]),
    .sum_z    (aq[2]),
    .rsp      (nrsp),
    .normal_x (normal_x),
    .normal_y (normal_y),
    .normal_z (normal_z)
  );

  assign done       = nrsp.done;
  assign degenerate = nrsp.degenerate;

endmodule

/* rtl/core/vnacc_checker.sv */
// Port-level checker of the vertex normal accumulator and its bind to the top level.
`timescale 1ns / 1ps
`include "vertex_normal_accumulator_top_defines.svh"
module vnacc_checker
  import vnacc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [1:0]        mode,
  input logic              done,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic              degenerate
);

  // A result only appears while a read request is in progress.
  `VNACC_ASSERT_NOW(a_done_busy, done, busy, "result strobe outside a request")
  // A load request completes in its own cycle and produces no result.
  `VNACC_ASSERT_NEXT(a_load_quick, start && !busy && mode == MODE_LOAD, !busy && !done, "load did not finish at once")
  // A read request keeps the block busy until its result.
  `VNACC_ASSERT_NEXT(a_read_busy, start && !busy && mode == MODE_READ, busy && !done, "read did not hold busy")
  // A degenerate result carries zero components.
  `VNACC_ASSERT_NOW(a_deg_zero, done && degenerate, normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0, "degenerate result with nonzero components")
  // The result strobe lasts one cycle.
  `VNACC_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule

bind vertex_normal_accumulator_top vnacc_checker u_vnacc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .mode       (mode),
  .done       (done),
  .normal_x   (normal_x),
  .normal_y   (normal_y),
  .normal_z   (normal_z),
  .degenerate (degenerate)
);

/* test/vertex_normal_accumulator_checker.sv */
// Checker that predicts and compares the normals returned by the vertex normal accumulator.
`timescale 1ns / 1ps
module vertex_normal_accumulator_checker
  import vnacc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         mode,
  input  logic [9:0]         vertex_index,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic [9:0]         corner_a,
  input  logic [9:0]         corner_b,
  input  logic [9:0]         corner_c,
  input  logic               done,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic               degenerate,
  output int                 mismatches,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  logic signed [15:0] vert_pos [MAX_VERTICES][3];
  longint             vert_sum [MAX_VERTICES][3];
  normal_t            normals_due [$];

  function automatic longint clamp_sum(longint acc, longint d);
    longint s;
    s = acc + d;
    if (s > SUM_MAX) return SUM_MAX;
    if (s < SUM_MIN) return SUM_MIN;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic normal_t unit_normal(int v);
    normal_t        n;
    longint unsigned mag [3];
    longint unsigned m, len2, r, q;
    logic [15:0]    comp [3];
    for (int i = 0; i < 3; i++) begin
      mag[i] = vert_sum[v][i] < 0 ? 64'd0 - longint'(vert_sum[v][i]) : vert_sum[v][i];
    end
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
    n = '0;
    if (m == 0) begin
      n.degen = 1'b1;
      return n;
    end
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      m = m >> 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      m = m << 1;
    end
    len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    r = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 14) + (r >> 1)) / r;
      if (vert_sum[v][i] < 0) q = 64'd0 - q;
      comp[i] = q[15:0];
    end
    n.nx = comp[0];
    n.ny = comp[1];
    n.nz = comp[2];
    return n;
  endfunction

  task automatic add_triangle(int a, int b, int c);
    longint e1 [3];
    longint e2 [3];
    longint cr [3];
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(vert_pos[b][i]) - longint'(vert_pos[a][i]);
      e2[i] = longint'(vert_pos[c][i]) - longint'(vert_pos[a][i]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int i = 0; i < 3; i++) vert_sum[a][i] = clamp_sum(vert_sum[a][i], cr[i]);
    for (int i = 0; i < 3; i++) vert_sum[b][i] = clamp_sum(vert_sum[b][i], cr[i]);
    for (int i = 0; i < 3; i++) vert_sum[c][i] = clamp_sum(vert_sum[c][i], cr[i]);
  endtask

  initial begin
    mismatches = 0;
    for (int v = 0; v < MAX_VERTICES; v++) begin
      for (int i = 0; i < 3; i++) begin
        vert_pos[v][i] = '0;
        vert_sum[v][i] = 0;
      end
    end
  end

  assign pending = normals_due.size();

  always @(posedge clk) begin
    normal_t want;
    if (!rst) begin
      if (done) begin
        if (normals_due.size() == 0) begin
          if (mismatches < 10) $display("checker: normal returned with none expected");
          mismatches <= mismatches + 1;
        end else begin
          want = normals_due.pop_front();
          if (normal_x !== want.nx || normal_y !== want.ny || normal_z !== want.nz ||
              degenerate !== want.degen) begin
            if (mismatches < 10) begin
              $display("checker: expected (%0d %0d %0d deg %0d) got (%0d %0d %0d deg %0d)",
                       want.nx, want.ny, want.nz, want.degen,
                       normal_x, normal_y, normal_z, degenerate);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start && !busy) begin
        case (mode_t'(mode))
          MODE_LOAD: begin
            vert_pos[vertex_index][0] = pos_x;
            vert_pos[vertex_index][1] = pos_y;
            vert_pos[vertex_index][2] = pos_z;
            for (int i = 0; i < 3; i++) vert_sum[vertex_index][i] = 0;
          end
          MODE_TRI: add_triangle(corner_a, corner_b, corner_c);
          MODE_READ: normals_due.push_back(unit_normal(vertex_index));
          default: ;
        endcase
      end
    end
  end

endmodule

/* test/tb.sv */
// Testbench top that drives requests into the vertex normal accumulator and reports the verdict.
`timescale 1ns / 1ps
module tb;
  import vnacc_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 1000000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         mode;
  logic [9:0]         vertex_index;
  logic signed [15:0] pos_x, pos_y, pos_z;
  logic [9:0]         corner_a, corner_b, corner_c;
  logic               done;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic               degenerate;
  int                 mismatches;
  int                 pending;
  int                 cycles;
  int                 mode_count [4];
  logic               loaded [MAX_VERTICES];
  int                 loaded_list [$];

  vertex_normal_accumulator_top dut (.*);

  vertex_normal_accumulator_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_request(mode_t m, int vi, logic [15:0] x, logic [15:0] y,
                              logic [15:0] z, int a, int b, int c);
    start        <= 1'b1;
    mode         <= m;
    vertex_index <= 10'(vi);
    pos_x        <= x;
    pos_y        <= y;
    pos_z        <= z;
    corner_a     <= 10'(a);
    corner_b     <= 10'(b);
    corner_c     <= 10'(c);
    do @(posedge clk); while (busy);
    mode_count[m]++;
    if (m == MODE_LOAD && !loaded[vi]) begin
      loaded[vi] = 1'b1;
      loaded_list.push_back(vi);
    end
  endtask

  task automatic random_request(mode_t m, int vi, int a, int b, int c);
    send_request(m, vi, 16'($urandom), 16'($urandom), 16'($urandom), a, b, c);
  endtask

  function automatic int pick_loaded();
    if ($urandom_range(0, 3) != 0 && loaded_list.size() > 24)
      return loaded_list[$urandom_range(0, 15)];
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  initial begin
    int sel;
    int vi;
    start = 1'b0; mode = MODE_NONE; vertex_index = '0;
    pos_x = '0; pos_y = '0; pos_z = '0;
    corner_a = '0; corner_b = '0; corner_c = '0;
    for (int v = 0; v < MAX_VERTICES; v++) loaded[v] = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(MODE_LOAD, 0, 16'h8000, 16'h8000, 16'h8000, $urandom, $urandom, $urandom);
    send_request(MODE_LOAD, 1, 16'h7FFF, 16'h8000, 16'h8000, $urandom, $urandom, $urandom);
    send_request(MODE_LOAD, 2, 16'h8000, 16'h7FFF, 16'h7FFF, $urandom, $urandom, $urandom);
    send_request(MODE_LOAD, 1023, 16'h7FFF, 16'h7FFF, 16'h0000, $urandom, $urandom, 0);
    send_request(MODE_READ, 0, 0, 0, 0, 0, 0, 0);
    send_request(MODE_TRI, 0, 0, 0, 0, 0, 1, 2);
    send_request(MODE_READ, 0, 0, 0, 0, 0, 0, 0);
    send_request(MODE_READ, 2, 0, 0, 0, 0, 0, 0);
    send_request(MODE_TRI, 0, 0, 0, 0, 1023, 1023, 1);
    send_request(MODE_READ, 1023, 0, 0, 0, 0, 0, 0);
    send_request(MODE_TRI, 0, 0, 0, 0, 2, 1023, 0);
    send_request(MODE_TRI, 0, 0, 0, 0, 1, 2, 1023);
    send_request(MODE_READ, 1023, 0, 0, 0, 0, 0, 0);
    send_request(MODE_READ, 1, 0, 0, 0, 0, 0, 0);
    send_request(MODE_NONE, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1023, 1023, 1023);
    send_request(MODE_LOAD, 0, 16'h0100, 16'h0000, 16'h0000, 0, 0, 0);
    send_request(MODE_READ, 0, 0, 0, 0, 0, 0, 0);
    for (int k = 0; k < 30; k++) random_request(MODE_LOAD, $urandom_range(0, 1023), 0, 0, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
      end else if (n < RANDOM_ITEMS - 100 && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        vi = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : pick_loaded();
        random_request(MODE_LOAD, vi, $urandom, $urandom, $urandom);
      end else if (sel < 72) begin
        random_request(MODE_TRI, $urandom, pick_loaded(), pick_loaded(), pick_loaded());
      end else if (sel < 95) begin
        random_request(MODE_READ, pick_loaded(), $urandom, $urandom, $urandom);
      end else begin
        random_request(MODE_NONE, $urandom, $urandom, $urandom, $urandom);
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("tb: covered %0d loads, %0d triangles, %0d reads and %0d ignored requests",
             mode_count[MODE_LOAD], mode_count[MODE_TRI], mode_count[MODE_READ],
             mode_count[MODE_NONE]);
    $display("tb: %0d distinct vertices loaded, %0d mismatches", loaded_list.size(), mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
